// File: src/led_strip_fade_frame_engine_unit_defines.svh
// Assertion macros shared by the frame engine RTL.
`ifndef LED_STRIP_FADE_FRAME_ENGINE_UNIT_DEFINES_SVH
`define LED_STRIP_FADE_FRAME_ENGINE_UNIT_DEFINES_SVH

// Plain property, sampled on the rising clock edge, off while in reset.
`define LSFE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in one cycle implies the consequent in the next.
`define LSFE_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/lsfe_pkg.sv
package lsfe_pkg;

   localparam int PIXEL_COUNT_DEF = 8;

   localparam logic [31:0] PIXEL_RESET_WORD = 32'h0000_0003;
   localparam logic [7:0]  HEADER_BASE      = 8'hE0;

   typedef enum logic [2:0] {
      FN_WRITE_CUR = 3'd0,
      FN_WRITE_TGT = 3'd1,
      FN_FADE      = 3'd2,
      FN_RISE      = 3'd3,
      FN_XFADE     = 3'd4,
      FN_SHOW      = 3'd5
   } func_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPD_RD,
      ST_UPD_CALC,
      ST_UPD_DIV,
      ST_UPD_WR,
      ST_EMIT_PRE,
      ST_EMIT_RD,
      ST_EMIT_OUT
   } state_type;

   typedef enum logic [1:0] {
      SEL_HDR = 2'd0,
      SEL_B   = 2'd1,
      SEL_G   = 2'd2,
      SEL_R   = 2'd3
   } byte_sel_type;

endpackage

// File: src/led_strip_fade_frame_engine_unit.sv
// LED strip fade and frame engine. Holds a current and a target store of PIXEL_COUNT
// pixel words (R, G, B, brightness) in two synchronous RAMs, each with one write port and
// one registered read port; entries read as 0x00000003 until first written (per-entry
// valid flops, no clearing pass after reset). Write items are done in the idle state.
// Step items walk the pixels through a read-modify-write loop on the current RAM: fade
// and rise read, then write back; crossfade reads, loads, runs three parallel radix-2
// restoring dividers, then writes back. Every step and show item then emits a frame of
// 4 + 4*PIXEL_COUNT bytes at one byte per cycle while rsp_ready is high, plus one RAM
// read per pixel. One item is in work at a time; req_ready is high only between items.
`include "led_strip_fade_frame_engine_unit_defines.svh"

module led_strip_fade_frame_engine_unit
   import lsfe_pkg::*;
#(
   parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_func,
   input  logic [2:0]  req_pixel_index,
   input  logic [31:0] req_pixel_word,
   input  logic [7:0]  req_step_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_last,
   output logic        rsp_faded_out
);

   localparam int AW = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
   localparam logic [AW-1:0] LAST_PIX = AW'(PIXEL_COUNT - 1);

   state_type       state_ff, state_in;
   func_type        func_ff;
   logic [7:0]      sv_ff;
   logic [AW-1:0]   pix_ff;
   logic [1:0]      sel_ff;
   logic [2:0]      div_cnt_ff;
   logic            dark_ff;

   logic [31:0]     cur_mem_ff [PIXEL_COUNT];
   logic [31:0]     tgt_mem_ff [PIXEL_COUNT];
   logic [PIXEL_COUNT-1:0] cur_vld_ff, tgt_vld_ff;
   logic [31:0]     cur_q_ff, tgt_q_ff;
   logic            cur_ok_ff, tgt_ok_ff;

   logic [7:0]      dvd_ff [3];
   logic [7:0]      rem_ff [3];
   logic [7:0]      quo_ff [3];

   logic            rsp_valid_ff;
   logic [7:0]      rsp_byte_ff;
   logic            rsp_last_ff;
   logic            rsp_flag_ff;

   logic            req_take, load_ok, pix_last;
   logic            rd_en, cur_we, tgt_we, load_out;
   logic [AW-1:0]   cur_wa, tgt_wa;
   logic [31:0]     cur_wd;
   logic [7:0]      out_byte_nx;
   logic            out_last_nx;
   logic            idx_ok;

   logic [31:0]     cur_w, tgt_w;
   logic [7:0]      divisor;
   logic [2:0]      fade_b;
   logic [2:0]      mix_b;
   logic [7:0]      cl [3];
   logic [7:0]      tl [3];
   logic [7:0]      diff_l [3];
   logic [7:0]      mov_l [3];
   logic [8:0]      trial [3];

   assign req_ready     = (state_ff == ST_IDLE);
   assign req_take      = req_valid && req_ready;
   assign load_ok       = !rsp_valid_ff || rsp_ready;
   assign pix_last      = (pix_ff == LAST_PIX);
   assign idx_ok        = int'(req_pixel_index) < PIXEL_COUNT;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_byte_ff;
   assign rsp_last      = rsp_last_ff;
   assign rsp_faded_out = rsp_flag_ff;

   // Entries never written read as the reset word.
   assign cur_w   = cur_ok_ff ? cur_q_ff : PIXEL_RESET_WORD;
   assign tgt_w   = tgt_ok_ff ? tgt_q_ff : PIXEL_RESET_WORD;
   assign divisor = (sv_ff == 8'd0) ? 8'd1 : sv_ff;

   always_comb begin
      fade_b = (cur_w[2:0] != 3'd0) ? cur_w[2:0] - 3'd1 : 3'd0;
      if (cur_w[2:0] > tgt_w[2:0]) begin
         mix_b = cur_w[2:0] - 3'd1;
      end else if (cur_w[2:0] < tgt_w[2:0]) begin
         mix_b = cur_w[2:0] + 3'd1;
      end else begin
         mix_b = cur_w[2:0];
      end
      for (int l = 0; l < 3; l++) begin
         cl[l]     = cur_w[8*(l+1) +: 8];
         tl[l]     = tgt_w[8*(l+1) +: 8];
         diff_l[l] = (cl[l] > tl[l]) ? cl[l] - tl[l] : tl[l] - cl[l];
         mov_l[l]  = (cl[l] > tl[l]) ? cl[l] - quo_ff[l] : cl[l] + quo_ff[l];
         trial[l]  = {rem_ff[l], dvd_ff[l][7]};
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               case (func_type'(req_func))
                  FN_FADE, FN_RISE, FN_XFADE: state_in = ST_UPD_RD;
                  FN_SHOW:                    state_in = ST_EMIT_PRE;
                  default:                    state_in = ST_IDLE;
               endcase
            end
         end
         ST_UPD_RD: state_in = ST_UPD_CALC;
         ST_UPD_CALC: begin
            if (func_ff == FN_XFADE) begin
               state_in = ST_UPD_DIV;
            end else begin
               state_in = pix_last ? ST_EMIT_PRE : ST_UPD_RD;
            end
         end
         ST_UPD_DIV: begin
            if (div_cnt_ff == 3'd7) begin
               state_in = ST_UPD_WR;
            end
         end
         ST_UPD_WR: state_in = pix_last ? ST_EMIT_PRE : ST_UPD_RD;
         ST_EMIT_PRE: begin
            if (load_ok && sel_ff == SEL_R) begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_EMIT_RD: state_in = ST_EMIT_OUT;
         ST_EMIT_OUT: begin
            if (load_ok && sel_ff == SEL_R) begin
               state_in = pix_last ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      rd_en       = 1'b0;
      cur_we      = 1'b0;
      tgt_we      = 1'b0;
      cur_wa      = pix_ff;
      tgt_wa      = AW'(req_pixel_index);
      cur_wd      = req_pixel_word;
      load_out    = 1'b0;
      out_byte_nx = 8'd0;
      out_last_nx = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && idx_ok) begin
               cur_wa = AW'(req_pixel_index);
               cur_we = (func_type'(req_func) == FN_WRITE_CUR);
               tgt_we = (func_type'(req_func) == FN_WRITE_TGT);
            end
         end
         ST_UPD_RD, ST_EMIT_RD: rd_en = 1'b1;
         ST_UPD_CALC: begin
            if (func_ff == FN_FADE) begin
               cur_we = 1'b1;
               cur_wd = {cur_w[31:8], 5'd0, fade_b};
            end else if (func_ff == FN_RISE) begin
               cur_we = 1'b1;
               cur_wd = {cur_w[31:8], sv_ff};
            end
         end
         ST_UPD_WR: begin
            cur_we = 1'b1;
            cur_wd = {mov_l[2], mov_l[1], mov_l[0], 5'd0, mix_b};
         end
         ST_EMIT_PRE: load_out = load_ok;
         ST_EMIT_OUT: begin
            load_out    = load_ok;
            out_last_nx = pix_last && (sel_ff == SEL_R);
            case (byte_sel_type'(sel_ff))
               SEL_HDR: out_byte_nx = HEADER_BASE | {3'd0, cur_w[4:0]};
               SEL_B:   out_byte_nx = cur_w[15:8];
               SEL_G:   out_byte_nx = cur_w[23:16];
               SEL_R:   out_byte_nx = cur_w[31:24];
               default: out_byte_nx = 8'd0;
            endcase
         end
         default: ;
      endcase
   end

   // Pixel RAMs: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (cur_we) begin
         cur_mem_ff[cur_wa] <= cur_wd;
      end
      if (tgt_we) begin
         tgt_mem_ff[tgt_wa] <= req_pixel_word;
      end
      if (rd_en) begin
         cur_q_ff <= cur_mem_ff[pix_ff];
         tgt_q_ff <= tgt_mem_ff[pix_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= '0;
         tgt_vld_ff <= '0;
         cur_ok_ff  <= 1'b0;
         tgt_ok_ff  <= 1'b0;
      end else begin
         if (cur_we) begin
            cur_vld_ff[cur_wa] <= 1'b1;
         end
         if (tgt_we) begin
            tgt_vld_ff[tgt_wa] <= 1'b1;
         end
         if (rd_en) begin
            cur_ok_ff <= cur_vld_ff[pix_ff];
            tgt_ok_ff <= tgt_vld_ff[pix_ff];
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item context, counters and the crossfade dividers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               func_ff    <= func_type'(req_func);
               sv_ff      <= req_step_value;
               dark_ff    <= (func_type'(req_func) == FN_FADE);
               pix_ff     <= '0;
               sel_ff     <= SEL_HDR;
               div_cnt_ff <= 3'd0;
            end
         end
         ST_UPD_CALC: begin
            if (func_ff == FN_XFADE) begin
               for (int l = 0; l < 3; l++) begin
                  dvd_ff[l] <= diff_l[l];
                  rem_ff[l] <= 8'd0;
                  quo_ff[l] <= 8'd0;
               end
            end else begin
               if (func_ff == FN_FADE && fade_b != 3'd0) begin
                  dark_ff <= 1'b0;
               end
               pix_ff <= pix_last ? '0 : pix_ff + AW'(1);
            end
         end
         ST_UPD_DIV: begin
            div_cnt_ff <= div_cnt_ff + 3'd1;
            for (int l = 0; l < 3; l++) begin
               dvd_ff[l] <= {dvd_ff[l][6:0], 1'b0};
               if (trial[l] >= {1'b0, divisor}) begin
                  rem_ff[l] <= 8'(trial[l] - {1'b0, divisor});
                  quo_ff[l] <= {quo_ff[l][6:0], 1'b1};
               end else begin
                  rem_ff[l] <= trial[l][7:0];
                  quo_ff[l] <= {quo_ff[l][6:0], 1'b0};
               end
            end
         end
         ST_UPD_WR: pix_ff <= pix_last ? '0 : pix_ff + AW'(1);
         ST_EMIT_PRE: begin
            if (load_ok) begin
               sel_ff <= sel_ff + 2'd1;
            end
         end
         ST_EMIT_OUT: begin
            if (load_ok) begin
               sel_ff <= sel_ff + 2'd1;
               if (sel_ff == SEL_R) begin
                  pix_ff <= pix_ff + AW'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // Output register payload
   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_byte_ff <= out_byte_nx;
         rsp_last_ff <= out_last_nx;
         rsp_flag_ff <= dark_ff && (func_ff == FN_FADE);
      end
   end

   `LSFE_ASSERT(a_wr_states, clock, reset, !cur_we || state_ff == ST_IDLE || state_ff == ST_UPD_CALC || state_ff == ST_UPD_WR, "current store written outside a write slot")
   `LSFE_ASSERT_NEXT(a_div_to_wr, clock, reset, state_ff == ST_UPD_DIV && div_cnt_ff == 3'd7, state_ff == ST_UPD_WR, "divider did not hand over to write back")
   `LSFE_ASSERT(a_last_alone, clock, reset, !(rsp_valid_ff && rsp_last_ff) || (state_ff != ST_EMIT_RD && state_ff != ST_EMIT_OUT), "frame still emitting after its last byte")

endmodule
